// ===== sv/i2t_pkg.sv =====
// ----------------------------------------------------------------------------
// i2t_pkg
// Types, codes and helper functions shared by the integer-to-text formatter.
// ----------------------------------------------------------------------------
package i2t_pkg;

    // Digit cells: enough for the ten decimal digits of a 32-bit operand.
    localparam int DIGIT_CELLS = 10;
    localparam int DIGIT_IDX_W = 4;
    localparam int VALUE_W     = 32;
    localparam int CONV_STEPS  = VALUE_W / 2;   // two operand bits per cycle
    localparam int STEP_CNT_W  = 4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;

    localparam logic [1:0] CONV_SDEC = 2'd0;
    localparam logic [1:0] CONV_UDEC = 2'd1;
    localparam logic [1:0] CONV_HEX  = 2'd2;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } i2t_state_t;

    typedef logic [3:0] digit_t;

    // Shift-and-add-3 correction; hex digits pass through untouched.
    function automatic digit_t dabble_adjust(input digit_t d, input logic hex_mode);
        digit_t r;
        if (!hex_mode && (d >= 4'd5))
        begin
            r = d + 4'd3;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    function automatic logic [7:0] digit_char(input digit_t d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            c = CHAR_UPPER + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== sv/i2t_in_if.sv =====
// ----------------------------------------------------------------------------
// i2t_in_if
// Operand and format options channel, valid/ready.
// ----------------------------------------------------------------------------
interface i2t_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  conversion;
    logic [1:0]  sign_mode;
    logic        left_justify;
    logic [5:0]  min_width;

    modport source (
        output valid, value, conversion, sign_mode, left_justify, min_width,
        input  ready
    );
    modport sink (
        input  valid, value, conversion, sign_mode, left_justify, min_width,
        output ready
    );
endinterface

// ===== sv/i2t_out_if.sv =====
// ----------------------------------------------------------------------------
// i2t_out_if
// Character stream channel, valid/ready, last marks the end of an item.
// ----------------------------------------------------------------------------
interface i2t_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (
        output valid, character, last,
        input  ready
    );
    modport sink (
        input  valid, character, last,
        output ready
    );
endinterface

// ===== sv/i2t_digit_cell.sv =====
// ----------------------------------------------------------------------------
// i2t_digit_cell
// One digit of the binary-to-digit shift chain. Takes two bits per cycle
// from the lower neighbor while shift is high and passes two bits up to the next cell.
// ----------------------------------------------------------------------------
module i2t_digit_cell (
    input  logic                 clk,
    input  logic                 clear,
    input  logic                 shift,
    input  logic                 hex_mode,
    input  logic [1:0]           carry_in,   // [1] is the earlier bit
    output logic [1:0]           carry_out,
    output i2t_pkg::digit_t      digit
);
    import i2t_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj1;
    digit_t mid;
    digit_t adj2;

    always_comb
    begin
        adj1         = dabble_adjust(digit_reg, hex_mode);
        carry_out[1] = adj1[3];
        mid          = {adj1[2:0], carry_in[1]};
        adj2         = dabble_adjust(mid, hex_mode);
        carry_out[0] = adj2[3];
        digit_next   = {adj2[2:0], carry_in[0]};
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            digit_reg <= '0;
        end
        else if (shift)
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

// ===== sv/integer_to_padded_text_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_padded_text_core
// Formats a 32-bit operand as signed decimal, unsigned decimal or upper-case
// hex text, padded with spaces to a minimum width, one character per output
// transfer with last on the final one. An item has N characters, where N is
// max(min_width, text length). The operand shifts two bits per cycle through
// the row of ten digit cells, a sizing state sizes the text, then characters
// leave one per cycle at the output register while the output is not stalled.
// A new item is taken once the previous one has been fully handed to the output
// register; an unused conversion code with min_width 0 yields no characters and
// still passes through the emit state. Output stalls hold the emission.
// ----------------------------------------------------------------------------
module integer_to_padded_text_core #(
    parameter int MAX_DIGITS = 11,
    parameter int MAX_WIDTH  = 63
) (
    input  logic      clk,
    input  logic      rst_n,
    i2t_in_if.sink    item,
    i2t_out_if.source text
);
    import i2t_pkg::*;

    localparam logic [4:0] MAX_DIGITS_C = 5'(MAX_DIGITS);
    localparam logic [5:0] MAX_WIDTH_C  = 6'(MAX_WIDTH);

    i2t_state_t state_reg, state_next;

    logic [VALUE_W-1:0]    mag_reg;
    logic [STEP_CNT_W-1:0] step_reg;
    logic [1:0]            conv_reg;
    logic [1:0]            smode_reg;
    logic                  left_reg;
    logic [5:0]            width_reg;
    logic                  neg_reg;

    logic [5:0]            padl_reg;
    logic [5:0]            padr_reg;
    logic [4:0]            txt_reg;
    logic [5:0]            rem_reg;
    logic                  sign_pend_reg;
    logic [7:0]            sign_char_reg;
    logic [DIGIT_IDX_W-1:0] dig_idx_reg;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;

    // digit chain
    logic       cell_clear;
    logic       cell_shift;
    logic [1:0] carry [DIGIT_CELLS+1];
    digit_t     digits [DIGIT_CELLS];

    assign carry[0] = mag_reg[VALUE_W-1 -: 2];

    genvar g;
    generate
        for (g = 0; g < DIGIT_CELLS; g++)
        begin : g_cell
            i2t_digit_cell u_cell (
                .clk       (clk),
                .clear     (cell_clear),
                .shift     (cell_shift),
                .hex_mode  (conv_reg == CONV_HEX),
                .carry_in  (carry[g]),
                .carry_out (carry[g+1]),
                .digit     (digits[g])
            );
        end
    endgenerate

    // text sizing
    logic [4:0] ndig;
    logic       has_sign;
    logic [4:0] text_len;
    logic [4:0] kept;
    logic       sign_pend;
    logic [7:0] sign_char;
    logic [5:0] wsat;
    logic [5:0] pad;
    logic [6:0] total;
    logic [4:0] dig_first;

    always_comb
    begin
        ndig = 5'd1;
        for (int i = 1; i < DIGIT_CELLS; i++)
        begin
            if (digits[i] != '0)
            begin
                ndig = 5'(i + 1);
            end
        end
        has_sign = (conv_reg == CONV_SDEC) &&
                   (neg_reg || (smode_reg == SIGN_PLUS) || (smode_reg == SIGN_SPACE));
        if (neg_reg)
        begin
            sign_char = CHAR_MINUS;
        end
        else if (smode_reg == SIGN_PLUS)
        begin
            sign_char = CHAR_PLUS;
        end
        else
        begin
            sign_char = CHAR_SPACE;
        end
        if ((conv_reg == CONV_SDEC) || (conv_reg == CONV_UDEC) || (conv_reg == CONV_HEX))
        begin
            text_len = ndig + {4'd0, has_sign};
        end
        else
        begin
            text_len = '0;
        end
        kept      = (text_len > MAX_DIGITS_C) ? MAX_DIGITS_C : text_len;
        sign_pend = has_sign && (text_len <= MAX_DIGITS_C) && (text_len != '0);
        wsat      = (width_reg > MAX_WIDTH_C) ? MAX_WIDTH_C : width_reg;
        pad       = (wsat > {1'b0, kept}) ? (wsat - {1'b0, kept}) : '0;
        total     = {1'b0, pad} + {2'd0, kept};
        // digits go out lowest-aligned: the last (kept - sign) digits
        dig_first = kept - {4'd0, sign_pend} - 5'd1;
    end

    // emission
    logic       emit;
    logic [7:0] next_char;

    always_comb
    begin
        emit = (state_reg == ST_EMIT) && (rem_reg != '0) &&
               (!out_valid_reg || text.ready);
        if (padl_reg != '0)
        begin
            next_char = CHAR_SPACE;
        end
        else if (txt_reg != '0)
        begin
            next_char = sign_pend_reg ? sign_char_reg : digit_char(digits[dig_idx_reg]);
        end
        else
        begin
            next_char = CHAR_SPACE;
        end
    end

    assign item.ready = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last      = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        cell_clear = 1'b0;
        cell_shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    cell_clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_shift = 1'b1;
                if (step_reg == STEP_CNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((rem_reg == '0) || (emit && (rem_reg == 6'd1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && item.valid)
        begin
            conv_reg  <= item.conversion;
            smode_reg <= item.sign_mode;
            left_reg  <= item.left_justify;
            width_reg <= item.min_width;
            step_reg  <= '0;
            if ((item.conversion == CONV_SDEC) && item.value[VALUE_W-1])
            begin
                neg_reg <= 1'b1;
                mag_reg <= '0 - item.value;
            end
            else
            begin
                neg_reg <= 1'b0;
                mag_reg <= item.value;
            end
        end
        else if (state_reg == ST_CONV)
        begin
            mag_reg  <= {mag_reg[VALUE_W-3:0], 2'b00};
            step_reg <= step_reg + 1'b1;
        end

        if (state_reg == ST_PREP)
        begin
            padl_reg      <= left_reg ? '0 : pad;
            padr_reg      <= left_reg ? pad : '0;
            txt_reg       <= kept;
            rem_reg       <= total[5:0];
            sign_pend_reg <= sign_pend;
            sign_char_reg <= sign_char;
            dig_idx_reg   <= dig_first[DIGIT_IDX_W-1:0];
        end
        else if (emit)
        begin
            rem_reg <= rem_reg - 6'd1;
            if (padl_reg != '0)
            begin
                padl_reg <= padl_reg - 6'd1;
            end
            else if (txt_reg != '0)
            begin
                txt_reg <= txt_reg - 5'd1;
                if (sign_pend_reg)
                begin
                    sign_pend_reg <= 1'b0;
                end
                else
                begin
                    dig_idx_reg <= dig_idx_reg - 1'b1;
                end
            end
            else
            begin
                padr_reg <= padr_reg - 6'd1;
            end
        end

        if (emit)
        begin
            out_char_reg <= next_char;
            out_last_reg <= (rem_reg == 6'd1);
        end
    end

endmodule
